// ----- sv/prf_pkg.sv -----
// Package for the page relocation fixup block: sizes, command codes, register map and word types.
package prf_pkg;

    // Number of 32-bit words in the page store.
    localparam int PAGE_WORDS = 1024;
    localparam int ADDR_W     = (PAGE_WORDS > 1) ? $clog2(PAGE_WORDS) : 1;

    localparam int INDEX_W    = 10;
    localparam int OFFSET_W   = 12;
    localparam int HALF_W     = 16;
    localparam int ENTRY_W    = 16;
    localparam int WORD_W     = 32;

    localparam int DATA_W     = 32;
    localparam int PADDR_W    = 4;

    localparam logic [HALF_W-1:0] THRESHOLD_RESET = 16'd8192;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_RELOC = 2'd1,
        CMD_FIXUP = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_CODE_DELTA = 2'd0,
        REG_DATA_DELTA = 2'd1,
        REG_THRESHOLD  = 2'd2,
        REG_UNUSED     = 2'd3
    } reg_index_t;

    typedef struct packed {
        cmd_t                cmd;
        logic [INDEX_W-1:0]  word_index;
        logic [WORD_W-1:0]   load_word;
        logic [ENTRY_W-1:0]  reloc_entry;
        logic [OFFSET_W-1:0] fixup_offset;
        logic [HALF_W-1:0]   fixup_low;
        logic [HALF_W-1:0]   fixup_high;
    } prf_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] touched_index;
        logic [WORD_W-1:0]  word_value;
    } prf_result_t;

endpackage

// ----- sv/page_relocation_fixup.sv -----
// Page relocation fixup block: page store memory, fixup datapath and configuration registers.

// The block holds one page of 32-bit words in a single-port-read, single-port-write
// synchronous memory and applies load, relocation, import fixup and read commands to it.
// It takes one command word per clock: busy is always low, so a command is accepted at
// every edge where start is high. Each command yields exactly one result word, shown on
// result for one cycle with done high, after the modify and result stages; the
// receiver cannot hold results off and none is needed, since results leave at the same
// rate that commands arrive. The page memory sets this pipeline: the word is read at
// acceptance, modified in the following cycle and written back at its end, while the next
// command's read goes on in parallel. A command that addresses the word written by the
// command just ahead of it takes that value from the result register instead of the
// memory. The page store has no reset and needs no clearing pass; a word must be loaded
// or fixed up before it is relocated or read. An index beyond the page leaves the store
// unchanged and returns zero. Configuration registers sit at byte addresses 0 (code
// delta), 4 (data delta) and 8 (data type threshold); the user must see that they are
// written only while no command is in flight, as the block itself does not enforce it.
module page_relocation_fixup
    import prf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               start,
    output logic               busy,
    input  prf_item_t          item,

    output logic               done,
    output prf_result_t        result,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    // Configuration registers.
    logic [WORD_W-1:0] code_delta_reg;
    logic [WORD_W-1:0] data_delta_reg;
    logic [HALF_W-1:0] threshold_reg;

    // Page store and its registered read port.
    logic [WORD_W-1:0] page_store_reg [PAGE_WORDS];
    logic [WORD_W-1:0] rd_data_reg;

    // Modify stage.
    logic               s1_valid_reg;
    cmd_t               s1_cmd_reg;
    logic [INDEX_W-1:0] s1_idx_reg;
    logic               s1_inside_reg;
    logic               s1_use_data_reg;
    logic [WORD_W-1:0]  s1_imm_reg;

    // Result stage; also the forwarding source for the next command.
    logic               done_reg;
    prf_result_t        result_reg;
    logic               res_wrote_reg;
    logic               res_read_reg;

    logic               accept;
    logic               cfg_write;
    reg_index_t         cfg_sel;
    logic [INDEX_W-1:0] s0_idx;
    logic               s0_inside;
    logic [ADDR_W-1:0]  s0_addr;
    logic [WORD_W-1:0]  s0_imm;
    logic [WORD_W-1:0]  old_word;
    logic [WORD_W-1:0]  new_word;
    logic               s1_writes;
    logic [ADDR_W-1:0]  s1_addr;

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign pready  = 1'b1;
    assign cfg_sel = reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    // Register read-back.
    always_comb
    begin
        unique case (cfg_sel)
            REG_CODE_DELTA: prdata = code_delta_reg;
            REG_DATA_DELTA: prdata = data_delta_reg;
            REG_THRESHOLD:  prdata = {{(DATA_W-HALF_W){1'b0}}, threshold_reg};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_delta_reg <= '0;
            data_delta_reg <= '0;
            threshold_reg  <= THRESHOLD_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                REG_CODE_DELTA: code_delta_reg <= pwdata;
                REG_DATA_DELTA: data_delta_reg <= pwdata;
                REG_THRESHOLD:  threshold_reg  <= pwdata[HALF_W-1:0];
                default:        ;
            endcase
        end
    end

    // Address decode of the incoming command. Byte offsets drop their low two bits.
    always_comb
    begin
        unique case (item.cmd)
            CMD_RELOC: s0_idx = item.reloc_entry[OFFSET_W-1:2];
            CMD_FIXUP: s0_idx = item.fixup_offset[OFFSET_W-1:2];
            default:   s0_idx = item.word_index;
        endcase
        s0_inside = 32'(s0_idx) < PAGE_WORDS;
        s0_addr   = ADDR_W'(s0_idx);
        s0_imm    = (item.cmd == CMD_FIXUP) ? {item.fixup_high, item.fixup_low}
                                            : item.load_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg      <= item.cmd;
            s1_idx_reg      <= s0_idx;
            s1_inside_reg   <= s0_inside;
            s1_use_data_reg <= item.reloc_entry >= threshold_reg;
            s1_imm_reg      <= s0_imm;
        end
    end

    // The previous command's write lands at the same edge as this command's read,
    // so a match on that index takes the value from the result register.
    always_comb
    begin
        if (done_reg && res_wrote_reg && (result_reg.touched_index == s1_idx_reg))
        begin
            old_word = result_reg.word_value;
        end
        else
        begin
            old_word = rd_data_reg;
        end

        case (s1_cmd_reg)
            CMD_RELOC: new_word = old_word + (s1_use_data_reg ? data_delta_reg
                                                                : code_delta_reg);
            CMD_READ:  new_word = old_word;
            default:   new_word = s1_imm_reg;
        endcase

        s1_writes = s1_valid_reg && s1_inside_reg && (s1_cmd_reg != CMD_READ);
        s1_addr   = ADDR_W'(s1_idx_reg);
    end

    always_ff @(posedge clk)
    begin
        if (s1_writes)
        begin
            page_store_reg[s1_addr] <= new_word;
        end
        rd_data_reg <= page_store_reg[s0_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= 1'b0;
            res_wrote_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= s1_valid_reg;
            res_wrote_reg <= s1_writes;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            result_reg.touched_index <= s1_idx_reg;
            result_reg.word_value    <= s1_inside_reg ? new_word : '0;
            res_read_reg             <= s1_cmd_reg == CMD_READ;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Every accepted command yields its result from the result stage.
    a_accept_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 done)
        else $error("accepted command produced no result");

    // No result appears without an accepted command.
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 2))
        else $error("result without an accepted command");

    // A read right behind a command on the same index returns that command's value.
    a_read_forward: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(done) && res_read_reg
            && (result.touched_index == $past(result.touched_index)))
        |-> (result.word_value == $past(result.word_value)))
        else $error("read after update on the same word returned a stale value");

endmodule

// ----- tb/page_relocation_fixup_test.sv -----
// Testbench for page_relocation_fixup: random and directed page commands checked against a local page model.
`timescale 1ns / 100ps

module page_relocation_fixup_test;
    import prf_pkg::*;

    // Every input of the block starts at a known value.
    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        start   = 1'b0;
    prf_item_t   item    = '0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr  = '0;
    logic [DATA_W-1:0]  pwdata = '0;

    logic               busy;
    logic               done;
    prf_result_t        result;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    page_relocation_fixup u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 clk = ~clk;

    // Our own copy of the page and of the three registers. The page model is only
    // ever read at words that the stimulus has already loaded or fixed up.
    logic [WORD_W-1:0] page_model [PAGE_WORDS];
    logic [WORD_W-1:0] code_delta_cfg = '0;
    logic [WORD_W-1:0] data_delta_cfg = '0;
    logic [HALF_W-1:0] threshold_cfg  = THRESHOLD_RESET;

    // Command words waiting to be driven, and the page words we expect back.
    prf_item_t   pending_items [$];
    prf_result_t expected_words [$];

    // Which page words the generated stimulus has written so far. Reads and
    // relocations are aimed only at these, since an unwritten word is undefined.
    bit          page_written [PAGE_WORDS];
    int unsigned written_list [$];
    int unsigned last_index = 0;

    int unsigned send_idle_pct  = 38;
    int unsigned mismatch_count = 0;

    // Builds a command word with every field random; callers then set the fields
    // that matter for the command. Unused fields keep their random bits.
    function automatic prf_item_t random_item();
        prf_item_t it;
        it.cmd          = cmd_t'($urandom_range(3));
        it.word_index   = INDEX_W'($urandom);
        it.load_word    = WORD_W'($urandom);
        it.reloc_entry  = ENTRY_W'($urandom);
        it.fixup_offset = OFFSET_W'($urandom);
        it.fixup_low    = HALF_W'($urandom);
        it.fixup_high   = HALF_W'($urandom);
        return it;
    endfunction

    // Applies one accepted command to the page model and returns the word the
    // block must report. Relocation entries compare all 16 bits against the
    // threshold; byte offsets drop their two low bits.
    function automatic prf_result_t predict_page_word(input prf_item_t it);
        logic [INDEX_W-1:0] idx;
        prf_result_t        word;
        case (it.cmd)
            CMD_RELOC: idx = it.reloc_entry[OFFSET_W-1:2];
            CMD_FIXUP: idx = it.fixup_offset[OFFSET_W-1:2];
            default:   idx = it.word_index;
        endcase
        word.touched_index = idx;
        word.word_value    = '0;
        if (idx < PAGE_WORDS) begin
            case (it.cmd)
                CMD_LOAD:  page_model[idx] = it.load_word;
                CMD_RELOC: page_model[idx] = page_model[idx] +
                    ((it.reloc_entry < threshold_cfg) ? code_delta_cfg : data_delta_cfg);
                CMD_FIXUP: page_model[idx] = {it.fixup_high, it.fixup_low};
                default:   ;
            endcase
            word.word_value = page_model[idx];
        end
        return word;
    endfunction

    // Queues one command. The key is the word index for load and read, the whole
    // entry for a relocation and the byte offset for a fixup; data is the load
    // word or the fixup value with its high half on top.
    function automatic void queue_word(input cmd_t c, input logic [15:0] key,
                                       input logic [31:0] data);
        prf_item_t   it;
        int unsigned idx;
        it     = random_item();
        it.cmd = c;
        case (c)
            CMD_LOAD:
            begin
                it.word_index = key[INDEX_W-1:0];
                it.load_word  = data;
                idx           = 32'(key[INDEX_W-1:0]);
            end
            CMD_RELOC:
            begin
                it.reloc_entry = key;
                idx            = 32'(key[OFFSET_W-1:2]);
            end
            CMD_FIXUP:
            begin
                it.fixup_offset              = key[OFFSET_W-1:0];
                {it.fixup_high, it.fixup_low} = data;
                idx                          = 32'(key[OFFSET_W-1:2]);
            end
            default:
            begin
                it.word_index = key[INDEX_W-1:0];
                idx           = 32'(key[INDEX_W-1:0]);
            end
        endcase
        if ((c == CMD_LOAD || c == CMD_FIXUP) && !page_written[idx]) begin
            page_written[idx] = 1'b1;
            written_list.push_back(idx);
        end
        last_index = idx;
        pending_items.push_back(it);
    endfunction

    // Random command mix. A good share of commands hits the word touched just
    // before, so back-to-back read-modify-writes of one word get exercised.
    function automatic void queue_random_command();
        int unsigned pick;
        int unsigned idx;
        logic [3:0]  kind_bits;
        cmd_t        c;
        pick = $urandom_range(99);
        if (written_list.size() == 0 || pick < 20) begin
            c = CMD_LOAD;
        end else if (pick < 60) begin
            c = CMD_RELOC;
        end else if (pick < 80) begin
            c = CMD_FIXUP;
        end else begin
            c = CMD_READ;
        end

        pick = $urandom_range(99);
        if (pick < 35 && page_written[last_index]) begin
            idx = last_index;
        end else if ((c == CMD_LOAD || c == CMD_FIXUP) && pick >= 65) begin
            idx = $urandom_range(PAGE_WORDS - 1);
        end else begin
            idx = written_list[$urandom_range(written_list.size() - 1)];
        end

        case (c)
            CMD_LOAD:  queue_word(c, 16'(idx), $urandom);
            CMD_RELOC:
            begin
                // Matching the threshold's type nibble now and then puts the
                // entry right around the code/data boundary.
                kind_bits = ($urandom_range(3) == 0) ? threshold_cfg[15:12] : 4'($urandom);
                queue_word(c, {kind_bits, INDEX_W'(idx), 2'($urandom)}, '0);
            end
            CMD_FIXUP: queue_word(c, {4'($urandom), INDEX_W'(idx), 2'($urandom)}, $urandom);
            default:   queue_word(c, 16'(idx), '0);
        endcase
    endfunction

    function automatic void report_mismatch(input string what, input logic [31:0] want,
                                            input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
        end
    endfunction

    // APB write: setup cycle, then access cycle; the register takes the value at
    // the edge that ends the access cycle, which is when the mirror is updated.
    // A write to the spare address must leave every register as it was.
    task automatic write_register(input reg_index_t idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CODE_DELTA: code_delta_cfg = value;
            REG_DATA_DELTA: data_delta_cfg = value;
            REG_THRESHOLD:  threshold_cfg  = value[HALF_W-1:0];
            default:        ;
        endcase
    endtask

    // Waits until every queued word has been driven and every expected word has
    // come back. Checking on the falling edge keeps clear of the rising-edge
    // updates.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || start || expected_words.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Driver: a word is taken at an edge where start is high and busy is low; it
    // is predicted right there. While start is low the item bus carries junk.
    always @(posedge clk) begin
        if (!rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_words.push_back(predict_page_word(item));
            end
            if (!start || !busy) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    item  <= pending_items.pop_front();
                    start <= 1'b1;
                end else begin
                    item  <= random_item();
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: each result word is valid for the one cycle that done is high.
    always @(posedge clk) begin
        prf_result_t want;
        if (rst_n && done) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word", '0, result.word_value);
            end else begin
                want = expected_words.pop_front();
                if (result.touched_index !== want.touched_index) begin
                    report_mismatch("touched_index", 32'(want.touched_index),
                                    32'(result.touched_index));
                end
                if (result.word_value !== want.word_value) begin
                    report_mismatch("word_value", want.word_value, result.word_value);
                end
            end
        end
    end

    initial begin
        logic [31:0] code_v;
        logic [31:0] data_v;
        logic [15:0] thr_v;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset configuration: both deltas are zero, the threshold is 8192.
        @(negedge clk);
        queue_word(CMD_LOAD, 16'd0, 32'h0000_0000);
        queue_word(CMD_LOAD, 16'd1023, 32'hffff_ffff);
        queue_word(CMD_LOAD, 16'd512, 32'ha5a5_5a5a);
        queue_word(CMD_READ, 16'd0, '0);
        queue_word(CMD_READ, 16'd1023, '0);
        queue_word(CMD_RELOC, 16'h0000, '0);
        wait_idle();

        // Threshold stays at its reset value; the code delta wraps words around.
        write_register(REG_CODE_DELTA, 32'hffff_ffff);
        write_register(REG_DATA_DELTA, 32'h0000_0001);
        @(negedge clk);
        queue_word(CMD_RELOC, 16'h1ffc, '0);                 // just below threshold: code
        queue_word(CMD_RELOC, 16'h2003, '0);                 // at threshold, low bits set
        queue_word(CMD_RELOC, 16'hfffe, '0);                 // high entry: data
        queue_word(CMD_FIXUP, 16'h0801, 32'hffff_0000);
        queue_word(CMD_RELOC, 16'h0801, '0);                 // right behind the fixup
        queue_word(CMD_READ, 16'd512, '0);
        queue_word(CMD_FIXUP, 16'h0fff, 32'h0000_ffff);      // last byte of the page
        queue_word(CMD_FIXUP, 16'h0000, 32'h1234_abcd);
        queue_word(CMD_RELOC, 16'h3000, '0);
        queue_word(CMD_RELOC, 16'h3000, '0);
        queue_word(CMD_LOAD, 16'd5, 32'h7fff_ffff);
        queue_word(CMD_RELOC, 16'h2014, '0);                 // carries into the sign bit
        wait_idle();

        // Zero threshold sends every entry to the data delta; the spare register
        // address is written with all ones and must change nothing.
        write_register(REG_THRESHOLD, 32'h0000_0000);
        write_register(REG_DATA_DELTA, 32'h8000_0000);
        write_register(REG_CODE_DELTA, 32'h0000_0000);
        write_register(REG_UNUSED, 32'hffff_ffff);
        @(negedge clk);
        queue_word(CMD_RELOC, 16'h0000, '0);
        queue_word(CMD_RELOC, 16'h1ffc, '0);
        wait_idle();

        // Top threshold: only the all-ones entry uses the data delta.
        write_register(REG_THRESHOLD, 32'h0000_ffff);
        @(negedge clk);
        queue_word(CMD_RELOC, 16'hfffc, '0);
        queue_word(CMD_RELOC, 16'hffff, '0);
        queue_word(CMD_READ, 16'd1023, '0);
        wait_idle();

        // Random phases, each under its own register setting. The sender idles
        // 38 percent of the time at first, then 45, then streams back to back.
        for (int ph = 0; ph < 6; ph++) begin
            code_v = $urandom;
            data_v = $urandom;
            thr_v  = 16'($urandom);
            case (ph)
                0: thr_v = 16'h0000;
                1:
                begin
                    code_v = 32'h0000_0000;
                    data_v = 32'hffff_ffff;
                    thr_v  = 16'hffff;
                end
                2:
                begin
                    code_v = 32'hffff_ffff;
                    data_v = 32'h0000_0000;
                end
                3: thr_v = THRESHOLD_RESET;
                default: ;
            endcase
            write_register(REG_CODE_DELTA, code_v);
            write_register(REG_DATA_DELTA, data_v);
            write_register(REG_THRESHOLD, {16'h0000, thr_v});
            if (ph == 3) begin
                write_register(REG_UNUSED, $urandom);
            end
            @(negedge clk);
            send_idle_pct = (ph < 2) ? 38 : (ph < 4) ? 45 : 0;
            repeat (125) queue_random_command();
            wait_idle();
        end

        if (mismatch_count == 0 && expected_words.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog: set far beyond the slowest correct run.
    initial begin
        #400000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
